[rtl/core/rqi_pkg.sv]
// ----------------------------------------------------------------------------
// rqi_pkg: ray / quadric intersection shared definitions
// widths, register indexes, term tables and payload types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqi_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CFG_W     = 2 * WORD_BITS;
  localparam int unsigned CFG_IDX_W = 3;

  // ray vector element: origin minus center needs one bit more
  localparam int unsigned VW  = WORD_BITS + 1;
  localparam int unsigned PPW = 2 * VW;
  localparam int unsigned HPW = WORD_BITS + VW;
  localparam int unsigned LPW = WORD_BITS + VW + 1;
  // quadratic coefficients, discriminant, root
  localparam int unsigned QW  = 3 * WORD_BITS + 4;
  localparam int unsigned DW  = 2 * QW;
  localparam int unsigned RW  = QW;
  localparam int unsigned NUM_LIMBS = 4;
  localparam int unsigned LIMB_W    = (QW + NUM_LIMBS - 1) / NUM_LIMBS;
  localparam int unsigned ROW_W     = LIMB_W * (NUM_LIMBS + 1);
  // divider
  localparam int unsigned QB  = WORD_BITS + 1;
  localparam int unsigned NW  = QW + 2 + FRAC_BITS;
  localparam int unsigned CW  = QW + QB;
  localparam int unsigned SQW = QB + 2;

  localparam int unsigned NUM_VEC   = 7;
  localparam int unsigned NUM_COEF  = 10;
  localparam int unsigned NUM_TERMS = 27;
  localparam int unsigned NUM_GRP   = NUM_TERMS / 3;

  // vector element indexes
  localparam int unsigned V_RX = 0;
  localparam int unsigned V_RY = 1;
  localparam int unsigned V_RZ = 2;
  localparam int unsigned V_DX = 3;
  localparam int unsigned V_DY = 4;
  localparam int unsigned V_DZ = 5;
  localparam int unsigned V_ONE = 6;

  // coefficient indexes
  localparam int unsigned K_A = 0;
  localparam int unsigned K_B = 1;
  localparam int unsigned K_C = 2;
  localparam int unsigned K_D = 3;
  localparam int unsigned K_E = 4;
  localparam int unsigned K_F = 5;
  localparam int unsigned K_G = 6;
  localparam int unsigned K_H = 7;
  localparam int unsigned K_I = 8;
  localparam int unsigned K_J = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A_B   = 3'd0,
    REG_COEF_C_D   = 3'd1,
    REG_COEF_E_F   = 3'd2,
    REG_COEF_G_H   = 3'd3,
    REG_COEF_I_J   = 3'd4,
    REG_CENTER_X_Y = 3'd5,
    REG_CENTER_Z   = 3'd6
  } cfg_reg_e;

  // term list: a terms (6), b terms (12), c terms (9), in groups of three
  localparam int unsigned TERM_U [NUM_TERMS] = '{
    V_DX, V_DY, V_DZ, V_DX, V_DY, V_DX,
    V_RX, V_RY, V_RZ, V_RX, V_RY, V_RY, V_RZ, V_RX, V_RZ, V_DX, V_DY, V_DZ,
    V_RX, V_RY, V_RZ, V_RX, V_RY, V_RX, V_RX, V_RY, V_RZ};
  localparam int unsigned TERM_V [NUM_TERMS] = '{
    V_DX, V_DY, V_DZ, V_DY, V_DZ, V_DZ,
    V_DX, V_DY, V_DZ, V_DY, V_DX, V_DZ, V_DY, V_DZ, V_DX, V_ONE, V_ONE, V_ONE,
    V_RX, V_RY, V_RZ, V_RY, V_RZ, V_RZ, V_ONE, V_ONE, V_ONE};
  localparam int unsigned TERM_K [NUM_TERMS] = '{
    K_A, K_B, K_C, K_D, K_E, K_F,
    K_A, K_B, K_C, K_D, K_D, K_E, K_E, K_F, K_F, K_G, K_H, K_I,
    K_A, K_B, K_C, K_D, K_E, K_F, K_G, K_H, K_I};
  localparam int unsigned TERM_SH [NUM_TERMS] = '{
    0, 0, 0, 1, 1, 1,
    0, 0, 0, 0, 0, 0, 0, 0, 0, FRAC_BITS, FRAC_BITS, FRAC_BITS,
    0, 0, 0, 1, 1, 1, FRAC_BITS + 1, FRAC_BITS + 1, FRAC_BITS + 1};

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [QW-1:0]        quad_w_t;

  localparam word_t MISS_DIST = -(WORD_BITS'(1) << FRAC_BITS);
  localparam word_t DIST_MAX  = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t DIST_MIN  = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef struct packed {
    word_t origin_x;
    word_t origin_y;
    word_t origin_z;
    word_t dir_x;
    word_t dir_y;
    word_t dir_z;
  } ray_t;

  typedef struct packed {
    quad_w_t qa;
    quad_w_t qb;
    quad_w_t qc;
  } quad_t;

  typedef struct packed {
    logic    miss;
    quad_w_t qa;
    quad_w_t qb;
  } side_t;

endpackage

`default_nettype wire

[rtl/core/rqi_ray_if.sv]
// ----------------------------------------------------------------------------
// rqi_ray_if: ray input channel
// valid / ready handshake with origin and direction payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rqi_ray_if;
  logic                  valid;
  logic                  ready;
  rqi_pkg::word_t        origin_x;
  rqi_pkg::word_t        origin_y;
  rqi_pkg::word_t        origin_z;
  rqi_pkg::word_t        dir_x;
  rqi_pkg::word_t        dir_y;
  rqi_pkg::word_t        dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/rqi_res_if.sv]
// ----------------------------------------------------------------------------
// rqi_res_if: intersection result channel
// valid / ready handshake with hit flag and distance payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rqi_res_if;
  logic           valid;
  logic           ready;
  logic           hit;
  rqi_pkg::word_t distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

`default_nettype wire

[rtl/core/rqi_coef.sv]
// ----------------------------------------------------------------------------
// rqi_coef: quadratic coefficient pipeline
// six stages: offset, pair products, coefficient products, terms, groups, sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqi_coef (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire rqi_pkg::ray_t  ray_i,
  input  wire rqi_pkg::word_t coef_i   [rqi_pkg::NUM_COEF],
  input  wire rqi_pkg::word_t center_i [3],
  output logic                valid_o,
  output rqi_pkg::quad_t      quad_o
);

  localparam int unsigned VW  = rqi_pkg::VW;
  localparam int unsigned PPW = rqi_pkg::PPW;
  localparam int unsigned HPW = rqi_pkg::HPW;
  localparam int unsigned LPW = rqi_pkg::LPW;
  localparam int unsigned QW  = rqi_pkg::QW;
  localparam int unsigned NT  = rqi_pkg::NUM_TERMS;
  localparam int unsigned NG  = rqi_pkg::NUM_GRP;
  localparam int unsigned NV  = rqi_pkg::NUM_VEC;

  logic [5:0] v_q;

  logic signed [VW-1:0]  vec_d  [NV];
  logic signed [VW-1:0]  vec_q  [NV];
  logic signed [PPW-1:0] pp_d   [NT];
  logic signed [PPW-1:0] pp_q   [NT];
  logic signed [VW-1:0]  hi_w   [NT];
  logic signed [VW:0]    lo_w   [NT];
  logic signed [HPW-1:0] hp_d   [NT];
  logic signed [HPW-1:0] hp_q   [NT];
  logic signed [LPW-1:0] lp_d   [NT];
  logic signed [LPW-1:0] lp_q   [NT];
  logic signed [QW-1:0]  term_d [NT];
  logic signed [QW-1:0]  term_q [NT];
  logic signed [QW-1:0]  grp_d  [NG];
  logic signed [QW-1:0]  grp_q  [NG];
  rqi_pkg::quad_t        quad_d;
  rqi_pkg::quad_t        quad_q;

  always_comb begin
    vec_d[rqi_pkg::V_RX]  = VW'(ray_i.origin_x) - VW'(center_i[0]);
    vec_d[rqi_pkg::V_RY]  = VW'(ray_i.origin_y) - VW'(center_i[1]);
    vec_d[rqi_pkg::V_RZ]  = VW'(ray_i.origin_z) - VW'(center_i[2]);
    vec_d[rqi_pkg::V_DX]  = VW'(ray_i.dir_x);
    vec_d[rqi_pkg::V_DY]  = VW'(ray_i.dir_y);
    vec_d[rqi_pkg::V_DZ]  = VW'(ray_i.dir_z);
    vec_d[rqi_pkg::V_ONE] = VW'(1);
  end

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      pp_d[t] = vec_q[rqi_pkg::TERM_U[t]] * vec_q[rqi_pkg::TERM_V[t]];
      // split the pair product so each coefficient product stays narrow
      hi_w[t] = signed'(pp_q[t][PPW-1:VW]);
      lo_w[t] = signed'({1'b0, pp_q[t][VW-1:0]});
      hp_d[t] = coef_i[rqi_pkg::TERM_K[t]] * hi_w[t];
      lp_d[t] = coef_i[rqi_pkg::TERM_K[t]] * lo_w[t];
      term_d[t] = ((QW'(hp_q[t]) <<< VW) + QW'(lp_q[t])) <<< rqi_pkg::TERM_SH[t];
    end
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = term_q[3*g] + term_q[3*g+1] + term_q[3*g+2];
    end
    quad_d.qa = grp_q[0] + grp_q[1];
    quad_d.qb = grp_q[2] + grp_q[3] + grp_q[4] + grp_q[5];
    quad_d.qc = grp_q[6] + grp_q[7] + grp_q[8]
              + (QW'(coef_i[rqi_pkg::K_J]) <<< (2 * rqi_pkg::FRAC_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      pp_q   <= pp_d;
      hp_q   <= hp_d;
      lp_q   <= lp_d;
      term_q <= term_d;
      grp_q  <= grp_d;
      quad_q <= quad_d;
    end
  end

  assign valid_o = v_q[5];
  assign quad_o  = quad_q;

endmodule

`default_nettype wire

[rtl/core/rqi_disc.sv]
// ----------------------------------------------------------------------------
// rqi_disc: discriminant pipeline
// five stages: magnitudes, limb products, row sums, full products, difference
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqi_disc (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire rqi_pkg::quad_t         quad_i,
  output logic                        valid_o,
  output rqi_pkg::side_t              side_o,
  output logic [rqi_pkg::DW-1:0]      rad_o
);

  localparam int unsigned QW  = rqi_pkg::QW;
  localparam int unsigned DW  = rqi_pkg::DW;
  localparam int unsigned LW  = rqi_pkg::LIMB_W;
  localparam int unsigned NL  = rqi_pkg::NUM_LIMBS;
  localparam int unsigned RWD = rqi_pkg::ROW_W;

  logic [4:0] v_q;

  // stage 0
  logic [NL*LW-1:0] ma_q, mb_q, mc_q;
  logic             sac_q [4];
  logic             az_q  [4];
  rqi_pkg::side_t   sd_q  [4];
  // stage 1
  logic [2*LW-1:0]  pbb_q [NL][NL];
  logic [2*LW-1:0]  pac_q [NL][NL];
  // stage 2
  logic [RWD-1:0]   rbb_d [NL];
  logic [RWD-1:0]   rac_d [NL];
  logic [RWD-1:0]   rbb_q [NL];
  logic [RWD-1:0]   rac_q [NL];
  // stage 3
  logic [DW-1:0]    bb_d, ac_d, bb_q, ac_q;
  // stage 4
  logic [DW-1:0]    disc_d;
  logic             miss_d;
  logic [DW-1:0]    rad_q;
  rqi_pkg::side_t   side_q;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rbb_d[i] = '0;
      rac_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        rbb_d[i] = rbb_d[i] + (RWD'(pbb_q[i][j]) << (j * LW));
        rac_d[i] = rac_d[i] + (RWD'(pac_q[i][j]) << (j * LW));
      end
    end
    bb_d = '0;
    ac_d = '0;
    for (int i = 0; i < NL; i++) begin
      bb_d = bb_d + (DW'(rbb_q[i]) << (i * LW));
      ac_d = ac_d + (DW'(rac_q[i]) << (i * LW));
    end
    // b*b - a*c with the sign of a*c folded in
    disc_d = sac_q[3] ? (bb_q + ac_q) : (bb_q - ac_q);
    miss_d = disc_d[DW-1] | az_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q <= (NL*LW)'(quad_i.qa[QW-1] ? -quad_i.qa : quad_i.qa);
      mb_q <= (NL*LW)'(quad_i.qb[QW-1] ? -quad_i.qb : quad_i.qb);
      mc_q <= (NL*LW)'(quad_i.qc[QW-1] ? -quad_i.qc : quad_i.qc);
      sac_q[0] <= quad_i.qa[QW-1] ^ quad_i.qc[QW-1];
      az_q[0]  <= (quad_i.qa == '0);
      sd_q[0]  <= '{miss: 1'b0, qa: quad_i.qa, qb: quad_i.qb};
      for (int s = 1; s < 4; s++) begin
        sac_q[s] <= sac_q[s-1];
        az_q[s]  <= az_q[s-1];
        sd_q[s]  <= sd_q[s-1];
      end
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pbb_q[i][j] <= mb_q[i*LW +: LW] * mb_q[j*LW +: LW];
          pac_q[i][j] <= ma_q[i*LW +: LW] * mc_q[j*LW +: LW];
        end
      end
      rbb_q <= rbb_d;
      rac_q <= rac_d;
      bb_q  <= bb_d;
      ac_q  <= ac_d;
      rad_q <= miss_d ? '0 : disc_d;
      side_q <= '{miss: miss_d, qa: sd_q[3].qa, qb: sd_q[3].qb};
    end
  end

  assign valid_o = v_q[4];
  assign side_o  = side_q;
  assign rad_o   = rad_q;

endmodule

`default_nettype wire

[rtl/core/rqi_sqrt.sv]
// ----------------------------------------------------------------------------
// rqi_sqrt: pipelined integer square root
// one root bit per stage, restoring digit recurrence, floor result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqi_sqrt (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire rqi_pkg::side_t         side_i,
  input  wire logic [rqi_pkg::DW-1:0] rad_i,
  output logic                        valid_o,
  output rqi_pkg::side_t              side_o,
  output logic [rqi_pkg::RW-1:0]      root_o
);

  localparam int unsigned RW = rqi_pkg::RW;
  localparam int unsigned DW = rqi_pkg::DW;

  logic             v_q     [RW];
  rqi_pkg::side_t   side_q  [RW];
  logic [RW+1:0]    rem_q   [RW];
  logic [RW-1:0]    root_q  [RW];
  logic [DW-1:0]    x_q     [RW];

  logic [RW+1:0]    rem_in  [RW];
  logic [RW-1:0]    root_in [RW];
  logic [DW-1:0]    x_in    [RW];
  logic [RW+1:0]    rem_sh  [RW];
  logic [RW+1:0]    trial   [RW];
  logic [RW+1:0]    rem_d   [RW];
  logic [RW-1:0]    root_d  [RW];
  logic [DW-1:0]    x_d     [RW];

  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    x_in[0]    = rad_i;
    for (int s = 1; s < RW; s++) begin
      rem_in[s]  = rem_q[s-1];
      root_in[s] = root_q[s-1];
      x_in[s]    = x_q[s-1];
    end
    for (int s = 0; s < RW; s++) begin
      rem_sh[s] = {rem_in[s][RW-1:0], x_in[s][DW-1 -: 2]};
      trial[s]  = {root_in[s], 2'b01};
      if (rem_sh[s] >= trial[s]) begin
        rem_d[s]  = rem_sh[s] - trial[s];
        root_d[s] = {root_in[s][RW-2:0], 1'b1};
      end else begin
        rem_d[s]  = rem_sh[s];
        root_d[s] = {root_in[s][RW-2:0], 1'b0};
      end
      x_d[s] = {x_in[s][DW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RW; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < RW; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < RW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      rem_q  <= rem_d;
      root_q <= root_d;
      x_q    <= x_d;
    end
  end

  assign valid_o = v_q[RW-1];
  assign side_o  = side_q[RW-1];
  assign root_o  = root_q[RW-1];

endmodule

`default_nettype wire

[rtl/core/rqi_div.sv]
// ----------------------------------------------------------------------------
// rqi_div: root selection, floor division and saturation
// numerator and range stages, one quotient bit per stage, result stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqi_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic                   valid_i,
  input  wire rqi_pkg::side_t         side_i,
  input  wire logic [rqi_pkg::RW-1:0] root_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output rqi_pkg::word_t              dist_o
);

  localparam int unsigned QW  = rqi_pkg::QW;
  localparam int unsigned NW  = rqi_pkg::NW;
  localparam int unsigned CW  = rqi_pkg::CW;
  localparam int unsigned QB  = rqi_pkg::QB;
  localparam int unsigned SQW = rqi_pkg::SQW;
  localparam int unsigned WB  = rqi_pkg::WORD_BITS;

  // numerator stage
  logic                 v0_q;
  logic signed [QW+1:0] num_w;
  logic signed [NW-1:0] num_q;
  logic                 sa0_q, miss0_q;
  logic signed [QW-1:0] qa0_q;
  // range stage
  logic                 v1_q;
  logic [NW-1:0]        nmag_q;
  logic [QW-1:0]        dmag_q;
  logic                 neg1_q, ovf1_q, miss1_q;
  // quotient stages
  logic                 vs_q    [QB];
  logic [NW-1:0]        rem_q   [QB];
  logic [QB-1:0]        quo_q   [QB];
  logic [QW-1:0]        dm_q    [QB];
  logic                 neg_q   [QB];
  logic                 ovf_q   [QB];
  logic                 miss_q  [QB];
  logic [NW-1:0]        rem_in  [QB];
  logic [QB-1:0]        quo_in  [QB];
  logic [QW-1:0]        dm_in   [QB];
  logic [CW-1:0]        dsh     [QB];
  logic                 ge      [QB];
  logic [NW-1:0]        rem_d   [QB];
  logic [QB-1:0]        quo_d   [QB];
  // result stage
  logic                  vo_q, hit_q;
  rqi_pkg::word_t        dist_q, dist_d;
  logic signed [SQW-1:0] q_pos, q_sgn;
  logic                  rnz;

  always_comb begin
    // smaller root: -b - s for a > 0, -b + s for a < 0
    if (side_i.qa[QW-1]) begin
      num_w = -(QW+2)'(side_i.qb) + signed'((QW+2)'(root_i));
    end else begin
      num_w = -(QW+2)'(side_i.qb) - signed'((QW+2)'(root_i));
    end
  end

  always_comb begin
    rem_in[0] = nmag_q;
    quo_in[0] = '0;
    dm_in[0]  = dmag_q;
    for (int s = 1; s < QB; s++) begin
      rem_in[s] = rem_q[s-1];
      quo_in[s] = quo_q[s-1];
      dm_in[s]  = dm_q[s-1];
    end
    for (int s = 0; s < QB; s++) begin
      dsh[s]   = CW'(dm_in[s]) << (QB - 1 - s);
      ge[s]    = CW'(rem_in[s]) >= dsh[s];
      rem_d[s] = ge[s] ? (rem_in[s] - dsh[s][NW-1:0]) : rem_in[s];
      quo_d[s] = {quo_in[s][QB-2:0], ge[s]};
    end
  end

  always_comb begin
    rnz   = |rem_q[QB-1];
    q_pos = signed'({2'b00, quo_q[QB-1]});
    q_sgn = neg_q[QB-1] ? (-q_pos - SQW'(rnz)) : q_pos;
    if (ovf_q[QB-1]) begin
      dist_d = neg_q[QB-1] ? rqi_pkg::DIST_MIN : rqi_pkg::DIST_MAX;
    end else if (q_sgn > SQW'(rqi_pkg::DIST_MAX)) begin
      dist_d = rqi_pkg::DIST_MAX;
    end else if (q_sgn < SQW'(rqi_pkg::DIST_MIN)) begin
      dist_d = rqi_pkg::DIST_MIN;
    end else begin
      dist_d = q_sgn[WB-1:0];
    end
    if (miss_q[QB-1]) begin
      dist_d = rqi_pkg::MISS_DIST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vo_q <= 1'b0;
      for (int s = 0; s < QB; s++) begin
        vs_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v0_q    <= valid_i;
      v1_q    <= v0_q;
      vs_q[0] <= v1_q;
      for (int s = 1; s < QB; s++) begin
        vs_q[s] <= vs_q[s-1];
      end
      vo_q <= vs_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= NW'(num_w) <<< rqi_pkg::FRAC_BITS;
      sa0_q   <= side_i.qa[QW-1];
      miss0_q <= side_i.miss;
      qa0_q   <= side_i.qa;

      nmag_q  <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
      dmag_q  <= sa0_q ? QW'(-qa0_q) : QW'(qa0_q);
      neg1_q  <= num_q[NW-1] ^ sa0_q;
      // quotient of 2^QB or more saturates either way
      ovf1_q  <= CW'(num_q[NW-1] ? NW'(-num_q) : NW'(num_q))
                 >= (CW'(sa0_q ? QW'(-qa0_q) : QW'(qa0_q)) << QB);
      miss1_q <= miss0_q;

      neg_q[0]  <= neg1_q;
      ovf_q[0]  <= ovf1_q;
      miss_q[0] <= miss1_q;
      for (int s = 1; s < QB; s++) begin
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        miss_q[s] <= miss_q[s-1];
      end
      rem_q <= rem_d;
      quo_q <= quo_d;
      dm_q  <= dm_in;

      hit_q  <= ~miss_q[QB-1];
      dist_q <= dist_d;
    end
  end

  assign valid_o = vo_q;
  assign hit_o   = hit_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

[rtl/core/ray_quadric_intersection.sv]
// ----------------------------------------------------------------------------
// ray_quadric_intersection: nearest ray / quadric root, fully pipelined
// configuration registers, four pipeline units and an output skid register
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  ray_i     in   valid / ready   origin_x/y/z, dir_x/y/z (signed Q16.16)
//  res_o     out  valid / ready   hit, distance (signed Q16.16)
//  cfg       in   cfg_we_i        cfg_idx_i, cfg_data_i (write only)
//
//  one beat per cycle sustained while the skid register is empty; at the
//  default widths: 6 coefficient, 5 discriminant, 100 root, 36 divide stages
//  the root unit resolves one bit per stage and sets most of the latency
//  reset clears all valid bits and the configuration registers, no sweep
//  all stages advance together while the skid register is empty; a stalled
//  result moves into the skid and the pipe freezes only once it is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_quadric_intersection (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rqi_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rqi_pkg::CFG_W-1:0]     cfg_data_i,
  rqi_ray_if.sink                            ray_i,
  rqi_res_if.source                          res_o
);

  localparam int unsigned WB = rqi_pkg::WORD_BITS;

  // configuration registers
  logic [rqi_pkg::CFG_W-1:0] coef_a_b_q, coef_c_d_q, coef_e_f_q;
  logic [rqi_pkg::CFG_W-1:0] coef_g_h_q, coef_i_j_q, center_x_y_q;
  logic [WB-1:0]             center_z_q;

  rqi_pkg::word_t coef   [rqi_pkg::NUM_COEF];
  rqi_pkg::word_t center [3];

  // pipeline
  logic                        pipe_en;
  rqi_pkg::ray_t               ray;
  logic                        coef_v, disc_v, sqrt_v, div_v;
  rqi_pkg::quad_t              quad;
  rqi_pkg::side_t              disc_side, sqrt_side;
  logic [rqi_pkg::DW-1:0]      rad;
  logic [rqi_pkg::RW-1:0]      root;
  logic                        div_hit;
  rqi_pkg::word_t              div_dist;

  // output skid
  logic           skid_v_q;
  logic           skid_hit_q;
  rqi_pkg::word_t skid_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_b_q   <= '0;
      coef_c_d_q   <= '0;
      coef_e_f_q   <= '0;
      coef_g_h_q   <= '0;
      coef_i_j_q   <= '0;
      center_x_y_q <= '0;
      center_z_q   <= '0;
    end else if (cfg_we_i) begin
      case (rqi_pkg::cfg_reg_e'(cfg_idx_i))
        rqi_pkg::REG_COEF_A_B:   coef_a_b_q   <= cfg_data_i;
        rqi_pkg::REG_COEF_C_D:   coef_c_d_q   <= cfg_data_i;
        rqi_pkg::REG_COEF_E_F:   coef_e_f_q   <= cfg_data_i;
        rqi_pkg::REG_COEF_G_H:   coef_g_h_q   <= cfg_data_i;
        rqi_pkg::REG_COEF_I_J:   coef_i_j_q   <= cfg_data_i;
        rqi_pkg::REG_CENTER_X_Y: center_x_y_q <= cfg_data_i;
        rqi_pkg::REG_CENTER_Z:   center_z_q   <= cfg_data_i[WB-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // unpack the coefficient words: high half first
  always_comb begin
    coef[rqi_pkg::K_A] = coef_a_b_q[2*WB-1:WB];
    coef[rqi_pkg::K_B] = coef_a_b_q[WB-1:0];
    coef[rqi_pkg::K_C] = coef_c_d_q[2*WB-1:WB];
    coef[rqi_pkg::K_D] = coef_c_d_q[WB-1:0];
    coef[rqi_pkg::K_E] = coef_e_f_q[2*WB-1:WB];
    coef[rqi_pkg::K_F] = coef_e_f_q[WB-1:0];
    coef[rqi_pkg::K_G] = coef_g_h_q[2*WB-1:WB];
    coef[rqi_pkg::K_H] = coef_g_h_q[WB-1:0];
    coef[rqi_pkg::K_I] = coef_i_j_q[2*WB-1:WB];
    coef[rqi_pkg::K_J] = coef_i_j_q[WB-1:0];
    center[0] = center_x_y_q[2*WB-1:WB];
    center[1] = center_x_y_q[WB-1:0];
    center[2] = center_z_q;
  end

  // pipe moves whenever the skid register has room
  assign pipe_en     = ~skid_v_q;
  assign ray_i.ready = pipe_en;

  assign ray = '{origin_x: ray_i.origin_x, origin_y: ray_i.origin_y,
                 origin_z: ray_i.origin_z, dir_x: ray_i.dir_x,
                 dir_y: ray_i.dir_y, dir_z: ray_i.dir_z};

  rqi_coef u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (ray_i.valid),
    .ray_i    (ray),
    .coef_i   (coef),
    .center_i (center),
    .valid_o  (coef_v),
    .quad_o   (quad)
  );

  rqi_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (coef_v),
    .quad_i  (quad),
    .valid_o (disc_v),
    .side_o  (disc_side),
    .rad_o   (rad)
  );

  rqi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (disc_v),
    .side_i  (disc_side),
    .rad_i   (rad),
    .valid_o (sqrt_v),
    .side_o  (sqrt_side),
    .root_o  (root)
  );

  rqi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (sqrt_v),
    .side_i  (sqrt_side),
    .root_i  (root),
    .valid_o (div_v),
    .hit_o   (div_hit),
    .dist_o  (div_dist)
  );

  // skid: catches the last stage when the sink stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (res_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (div_v && !res_o.ready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && div_v && !res_o.ready) begin
      skid_hit_q  <= div_hit;
      skid_dist_q <= div_dist;
    end
  end

  // the skid beat is older than the one in the last stage
  assign res_o.valid    = skid_v_q | div_v;
  assign res_o.hit      = skid_v_q ? skid_hit_q  : div_hit;
  assign res_o.distance = skid_v_q ? skid_dist_q : div_dist;

`ifndef SYNTH
  a_miss_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |-> res_o.distance == rqi_pkg::MISS_DIST)
    else $error("miss beat without the miss distance");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !res_o.ready |=> skid_v_q && $stable(skid_dist_q)
                                 && $stable(skid_hit_q))
    else $error("skid beat lost or changed while stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(div_v && !res_o.ready))
    else $error("skid filled without a stalled result");
`endif

endmodule

`default_nettype wire
